@@ rtl/core/lcm_unit_defines.svh @@
// Assertion macros used by the checker of the LCM block.
`ifndef LCM_UNIT_DEFINES_SVH
`define LCM_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LCM_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LCM_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lcm_pkg.sv @@
package lcm_pkg;

   // Operand width actually used; the low bits of each field are sign-extended.
   localparam int OPERAND_WIDTH = 32;
   localparam int FIELD_WIDTH   = 32;
   localparam int RESULT_WIDTH  = 64;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int COUNT_WIDTH   = $clog2(PROD_WIDTH);

   typedef logic [OPERAND_WIDTH-1:0]       mag_type;
   typedef logic [PROD_WIDTH-1:0]          prod_type;
   typedef logic [COUNT_WIDTH-1:0]         count_type;
   typedef logic [OPERAND_WIDTH:0]         shift_type;
   typedef logic [OPERAND_WIDTH+1:0]       diff_type;
   typedef logic signed [FIELD_WIDTH-1:0]  field_type;
   typedef logic signed [RESULT_WIDTH-1:0] result_type;

   // Last step index of a remainder pass and of the final quotient pass.
   localparam count_type REM_LAST = count_type'(OPERAND_WIDTH - 1);
   localparam count_type DIV_LAST = count_type'(PROD_WIDTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REM,
      ST_STEP,
      ST_MUL,
      ST_DIV,
      ST_SIGN,
      ST_DONE
   } state_type;

endpackage

@@ rtl/core/lcm_if.sv @@
// Request channel: two signed operands.
interface lcm_req_if;
   logic                 valid;
   logic                 ready;
   lcm_pkg::field_type   first_operand;
   lcm_pkg::field_type   second_operand;

   modport source (output valid, output first_operand, output second_operand, input ready);
   modport sink (input valid, input first_operand, input second_operand, output ready);
endinterface

// Response channel: one signed multiple.
interface lcm_rsp_if;
   logic                 valid;
   logic                 ready;
   lcm_pkg::result_type  multiple;

   modport source (output valid, output multiple, input ready);
   modport sink (input valid, input multiple, output ready);
endinterface

@@ rtl/core/lcm_unit.sv @@
// A zero second operand passes the first operand through; otherwise the unit
// runs Euclid remainder steps (1 to about 46 at 32 bits), each followed by one
// update step, and then the final 64-by-32 quotient of the operand product by the
// GCD, all on one shared restoring subtract-and-compare unit.
// A new request is taken only while idle; a finished result waits
// in an output register. Reset is synchronous, active high: idle, output empty.
module lcm_unit (
   input  logic      clock,
   input  logic      reset,
   lcm_req_if.sink   req_chan,
   lcm_rsp_if.source rsp_chan
);

   lcm_pkg::state_type  state_ff, state_in;
   lcm_pkg::mag_type    x_mag_ff, x_mag_in;
   logic                x_neg_ff, x_neg_in;
   lcm_pkg::mag_type    y_mag_ff, y_mag_in;
   logic                y_neg_ff, y_neg_in;
   lcm_pkg::mag_type    a_mag_ff, a_mag_in;
   lcm_pkg::mag_type    b_mag_ff, b_mag_in;
   lcm_pkg::mag_type    rem_ff, rem_in;
   lcm_pkg::prod_type   dvd_ff, dvd_in;
   lcm_pkg::count_type  cnt_ff, cnt_in;
   lcm_pkg::result_type result_ff, result_in;
   logic                out_valid_ff, out_valid_in;
   lcm_pkg::result_type out_data_ff, out_data_in;

   lcm_pkg::mag_type    a_low, b_low, a_abs, b_abs, divisor, rem_next;
   logic                a_neg, b_neg, fits;
   lcm_pkg::shift_type  shifted;
   lcm_pkg::diff_type   diff;
   lcm_pkg::prod_type   dvd_next, product;

   // Operand decode: low bits, sign and magnitude.
   assign a_low = req_chan.first_operand[lcm_pkg::OPERAND_WIDTH-1:0];
   assign b_low = req_chan.second_operand[lcm_pkg::OPERAND_WIDTH-1:0];
   assign a_neg = a_low[lcm_pkg::OPERAND_WIDTH-1];
   assign b_neg = b_low[lcm_pkg::OPERAND_WIDTH-1];
   assign a_abs = a_neg ? lcm_pkg::mag_type'(-a_low) : a_low;
   assign b_abs = b_neg ? lcm_pkg::mag_type'(-b_low) : b_low;

   // Shared restoring step: shift in one dividend bit, subtract if it fits.
   assign divisor  = (state_ff == lcm_pkg::ST_DIV) ? x_mag_ff : y_mag_ff;
   assign shifted  = {rem_ff, dvd_ff[lcm_pkg::PROD_WIDTH-1]};
   assign diff     = {1'b0, shifted} - {2'b00, divisor};
   assign fits     = ~diff[lcm_pkg::OPERAND_WIDTH+1];
   assign rem_next = fits ? diff[lcm_pkg::OPERAND_WIDTH-1:0]
                          : shifted[lcm_pkg::OPERAND_WIDTH-1:0];
   assign dvd_next = {dvd_ff[lcm_pkg::PROD_WIDTH-2:0], fits};

   // Exact product of the operand magnitudes.
   assign product = lcm_pkg::prod_type'(a_mag_ff) * lcm_pkg::prod_type'(b_mag_ff);

   assign req_chan.ready    = (state_ff == lcm_pkg::ST_IDLE);
   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.multiple = out_data_ff;

   // Sequencer state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcm_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_mag_ff    <= x_mag_in;
      x_neg_ff    <= x_neg_in;
      y_mag_ff    <= y_mag_in;
      y_neg_ff    <= y_neg_in;
      a_mag_ff    <= a_mag_in;
      b_mag_ff    <= b_mag_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      cnt_ff      <= cnt_in;
      result_ff   <= result_in;
      out_data_ff <= out_data_in;
   end

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      x_mag_in     = x_mag_ff;
      x_neg_in     = x_neg_ff;
      y_mag_in     = y_mag_ff;
      y_neg_in     = y_neg_ff;
      a_mag_in     = a_mag_ff;
      b_mag_in     = b_mag_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      result_in    = result_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff & ~rsp_chan.ready;

      unique case (state_ff)
         lcm_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               x_mag_in = a_abs;
               x_neg_in = a_neg;
               y_mag_in = b_abs;
               y_neg_in = b_neg;
               a_mag_in = a_abs;
               b_mag_in = b_abs;
               dvd_in   = lcm_pkg::prod_type'(a_abs) << lcm_pkg::OPERAND_WIDTH;
               rem_in   = '0;
               cnt_in   = '0;
               // A zero second operand passes the first operand through.
               if (b_low == '0) begin
                  result_in = lcm_pkg::result_type'($signed(a_low));
                  state_in  = lcm_pkg::ST_DONE;
               end else begin
                  state_in  = lcm_pkg::ST_REM;
               end
            end
         end
         lcm_pkg::ST_REM: begin
            rem_in = rem_next;
            dvd_in = dvd_next;
            cnt_in = lcm_pkg::count_type'(cnt_ff + 1'b1);
            if (cnt_ff == lcm_pkg::REM_LAST) begin
               state_in = lcm_pkg::ST_STEP;
            end
         end
         lcm_pkg::ST_STEP: begin
            // The remainder takes the sign of the dividend; shift the pair down.
            x_mag_in = y_mag_ff;
            x_neg_in = y_neg_ff;
            y_mag_in = rem_ff;
            y_neg_in = x_neg_ff;
            if (rem_ff == '0) begin
               state_in = lcm_pkg::ST_MUL;
            end else begin
               dvd_in   = lcm_pkg::prod_type'(y_mag_ff) << lcm_pkg::OPERAND_WIDTH;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = lcm_pkg::ST_REM;
            end
         end
         lcm_pkg::ST_MUL: begin
            dvd_in   = product;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = lcm_pkg::ST_DIV;
         end
         lcm_pkg::ST_DIV: begin
            rem_in = rem_next;
            dvd_in = dvd_next;
            cnt_in = lcm_pkg::count_type'(cnt_ff + 1'b1);
            if (cnt_ff == lcm_pkg::DIV_LAST) begin
               state_in = lcm_pkg::ST_SIGN;
            end
         end
         lcm_pkg::ST_SIGN: begin
            // The quotient follows the sign of the GCD.
            result_in = x_neg_ff ? -lcm_pkg::result_type'(dvd_ff)
                                 : lcm_pkg::result_type'(dvd_ff);
            state_in  = lcm_pkg::ST_DONE;
         end
         lcm_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_data_in  = result_ff;
               state_in     = lcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/lcm_checker.sv @@
`include "lcm_unit_defines.svh"

module lcm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input lcm_pkg::result_type rsp_multiple
);

   // The unit works on one request at a time.
   `LCM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a request")

   // No result can appear in the cycle right after a request is taken.
   `LCM_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "result appeared one cycle after a request")

   // A stalled result holds its value.
   `LCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_multiple), "stalled result dropped or changed")

   // Reset leaves the unit idle with no result pending.
   `LCM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "unit not idle after reset")

endmodule

bind lcm_unit lcm_checker u_lcm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_multiple (rsp_chan.multiple)
);
